>>> design/bbcm_pkg.sv
`timescale 1ns / 1ps
package bbcm_pkg;
    localparam int SLOTS = 4;
    localparam int SW = 2;
    localparam int CW = 3;

    typedef enum logic [2:0] {
        OP_ACQ_OVR  = 3'd0,
        OP_ACQ_RD   = 3'd1,
        OP_FILL     = 3'd2,
        OP_REL_CLN  = 3'd3,
        OP_REL_MOD  = 3'd4,
        OP_TICK     = 3'd5,
        OP_SYNC     = 3'd6,
        OP_SYNC_INV = 3'd7
    } t_op;

    localparam logic [1:0] K_ACQ  = 2'd0;
    localparam logic [1:0] K_WB   = 2'd1;
    localparam logic [1:0] K_DONE = 2'd2;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_DIRTY   = 2'd1;
    localparam logic [1:0] ST_CACHED  = 2'd2;

    localparam logic [1:0] REG_HOLD   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  device_id;
        logic [31:0] block_number;
        logic [1:0]  slot_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  out_slot;
        logic [3:0]  out_device;
        logic [31:0] out_block;
        logic        hit;
        logic        fill_needed;
        logic        error;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg;
endpackage

>>> design/bbcm_if.sv
`timescale 1ns / 1ps
interface bbcm_in_if;
    import bbcm_pkg::*;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbcm_out_if;
    import bbcm_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbcm_cfg_if;
    import bbcm_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/block_buffer_cache_manager_unit.sv
`timescale 1ns / 1ps
// channel   dir  payload
// i_in      in   opcode, device_id, block_number, slot_index
// o_out     out  kind, out_slot, out_device, out_block, hit, fill_needed, error, last
// i_cfg     in   index (0 hold_time, 1 tick_period, 2 tick_flush_limit), data
// A sequencer visits one queue entry per cycle, unless an output stall holds it,
// through a shared compare/subtract unit; each word waits in the output register
// until taken. Reset is synchronous and returns all slots to the clean queue.
// Output stalls hold aging, grant and emit; no input is taken meanwhile.
module block_buffer_cache_manager_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    bbcm_in_if.sink    i_in,
    bbcm_out_if.source o_out,
    bbcm_cfg_if.sink   i_cfg
);
    import bbcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SRCH_C, S_SRCH_D, S_AGE, S_GRANT, S_EMIT
    } t_state;

    t_state      r_state, r_after;
    t_in         r_item;
    t_out        r_out;
    logic        r_ovalid;
    logic [15:0] r_hold_time, r_tick_period;
    logic [4:0]  r_limit;

    logic [3:0]  r_dev [SLOTS];
    logic        r_vdev [SLOTS];
    logic [31:0] r_blk [SLOTS];
    logic [1:0]  r_st [SLOTS];
    logic [15:0] r_hold [SLOTS];
    logic [SW-1:0] r_cq [SLOTS];
    logic [SW-1:0] r_dq [SLOTS];
    logic [CW-1:0] r_cc, r_dc, r_kc, r_i;
    logic [15:0] r_amt;
    logic [4:0]  r_budget;
    logic        r_inval, r_miss, r_hit, r_stop;
    logic [SW-1:0] r_s;

    // shared unit: one entry per cycle unless the output stalls aging
    logic [SW-1:0] w_cs, w_ds, w_s;
    logic          w_match_c, w_match_d, w_gt;
    logic [15:0]   w_diff;
    logic          w_held;

    assign w_cs = r_cq[r_i[SW-1:0]];
    assign w_ds = r_dq[r_i[SW-1:0]];
    assign w_s  = (r_state == S_SRCH_C) ? w_cs : w_ds;
    assign w_match_c = r_vdev[w_s] && r_dev[w_s] == r_item.device_id
                       && r_blk[w_s] == r_item.block_number;
    assign w_match_d = w_match_c;
    assign w_gt   = r_hold[w_ds] > r_amt;
    assign w_diff = r_hold[w_ds] - r_amt;

    always_comb begin
        w_held = 1'b1;
        for (int k = 0; k < SLOTS; k++) begin
            if (CW'(k) < r_cc && r_cq[k] == r_item.slot_index) w_held = 1'b0;
            if (CW'(k) < r_dc && r_dq[k] == r_item.slot_index) w_held = 1'b0;
        end
    end

    logic w_out_free;
    logic w_wb_go, w_load;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_wb_go = (r_state == S_AGE) && w_out_free && (r_i < r_dc) && !r_stop
                     && !w_gt && (r_budget != '0);
    assign w_load = w_wb_go || (((r_state == S_GRANT) || (r_state == S_EMIT))
                                && w_out_free);

    assign i_in.ready   = (r_state == S_IDLE) && w_out_free;
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_ovalid;
    assign o_out.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_ovalid <= 1'b0;
            r_hold_time <= 16'd10000;
            r_tick_period <= 16'd2000;
            r_limit <= 5'd3;
            r_cc <= CW'(SLOTS);
            r_dc <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_dev[k] <= '0;
                r_vdev[k] <= 1'b0;
                r_blk[k] <= '0;
                r_st[k] <= ST_INVALID;
                r_hold[k] <= '0;
                r_cq[k] <= SW'(SLOTS - 1 - k);
            end
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_HOLD:   r_hold_time <= i_cfg.data.data;
                    REG_PERIOD: r_tick_period <= i_cfg.data.data;
                    REG_LIMIT:  r_limit <= i_cfg.data.data[4:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && w_out_free) begin
                        r_item <= i_in.data;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_i <= '0;
                    r_kc <= '0;
                    r_miss <= 1'b0;
                    r_hit <= 1'b0;
                    r_stop <= 1'b0;
                    unique case (t_op'(r_item.opcode))
                        OP_ACQ_OVR, OP_ACQ_RD: r_state <= S_SRCH_C;
                        OP_FILL: begin
                            if (w_held && r_st[r_item.slot_index] == ST_INVALID)
                                r_st[r_item.slot_index] <= ST_CACHED;
                            r_state <= S_EMIT;
                        end
                        OP_REL_CLN, OP_REL_MOD: begin
                            if (w_held) begin
                                if (r_item.opcode == OP_REL_MOD
                                    || r_st[r_item.slot_index] == ST_DIRTY) begin
                                    r_st[r_item.slot_index] <= ST_DIRTY;
                                    r_hold[r_item.slot_index] <= r_hold_time;
                                    r_dq[r_dc[SW-1:0]] <= r_item.slot_index;
                                    r_dc <= r_dc + 1'b1;
                                end else begin
                                    r_cq[r_cc[SW-1:0]] <= r_item.slot_index;
                                    r_cc <= r_cc + 1'b1;
                                end
                            end
                            r_state <= S_EMIT;
                        end
                        OP_TICK: begin
                            r_amt <= r_tick_period;
                            r_budget <= r_limit;
                            r_inval <= 1'b0;
                            r_state <= S_AGE;
                        end
                        default: begin
                            r_amt <= r_hold_time;
                            r_budget <= 5'(SLOTS);
                            r_inval <= (r_item.opcode == OP_SYNC_INV);
                            r_state <= S_AGE;
                        end
                    endcase
                end
                S_SRCH_C: begin
                    if (r_i >= r_cc) begin
                        r_i <= '0;
                        r_state <= S_SRCH_D;
                    end else if (w_match_c) begin
                        r_s <= w_cs;
                        r_hit <= 1'b1;
                        for (int k = 0; k < SLOTS - 1; k++)
                            if (CW'(k) >= r_i) r_cq[k] <= r_cq[k + 1];
                        r_cc <= r_cc - 1'b1;
                        r_state <= S_GRANT;
                    end else r_i <= r_i + 1'b1;
                end
                S_SRCH_D: begin
                    if (r_i >= r_dc) begin
                        r_i <= '0;
                        if (r_cc == '0) begin
                            r_amt <= r_hold_time;
                            r_budget <= 5'd1;
                            r_inval <= 1'b0;
                            r_miss <= 1'b1;
                            r_state <= S_AGE;
                        end else r_state <= S_GRANT;
                    end else if (w_match_d) begin
                        r_s <= w_ds;
                        r_hit <= 1'b1;
                        for (int k = 0; k < SLOTS - 1; k++)
                            if (CW'(k) >= r_i) r_dq[k] <= r_dq[k + 1];
                        r_dc <= r_dc - 1'b1;
                        r_state <= S_GRANT;
                    end else r_i <= r_i + 1'b1;
                end
                S_AGE: begin
                    if (w_out_free) begin
                        if (r_i >= r_dc) begin
                            r_dc <= r_kc;
                            r_state <= r_miss ? S_GRANT : S_EMIT;
                        end else if (r_stop) begin
                            // keep the rest unaged
                            r_dq[r_kc[SW-1:0]] <= w_ds;
                            r_kc <= r_kc + 1'b1;
                            r_i <= r_i + 1'b1;
                        end else if (w_gt) begin
                            r_hold[w_ds] <= w_diff;
                            r_dq[r_kc[SW-1:0]] <= w_ds;
                            r_kc <= r_kc + 1'b1;
                            r_i <= r_i + 1'b1;
                        end else if (r_budget == '0) begin
                            // budget spent: stop aging here
                            r_stop <= 1'b1;
                            r_dq[r_kc[SW-1:0]] <= w_ds;
                            r_kc <= r_kc + 1'b1;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_budget <= r_budget - 1'b1;
                            r_out <= '{kind: K_WB, out_slot: w_ds,
                                out_device: r_dev[w_ds], out_block: r_blk[w_ds],
                                hit: 1'b0, fill_needed: 1'b0, error: 1'b0,
                                last: 1'b0};
                            if (r_inval) begin
                                r_vdev[w_ds] <= 1'b0;
                                r_dev[w_ds] <= '0;
                                r_st[w_ds] <= ST_INVALID;
                            end else r_st[w_ds] <= ST_CACHED;
                            r_cq[r_cc[SW-1:0]] <= w_ds;
                            r_cc <= r_cc + 1'b1;
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_GRANT: begin
                    if (w_out_free) begin
                        if (r_hit) begin
                            r_out <= '{kind: K_ACQ, out_slot: r_s,
                                out_device: r_dev[r_s], out_block: r_blk[r_s],
                                hit: 1'b1,
                                fill_needed: r_item.opcode == OP_ACQ_RD
                                    && r_st[r_s] == ST_INVALID,
                                error: 1'b0, last: 1'b1};
                        end else if (r_cc == '0) begin
                            r_out <= '{kind: K_ACQ, out_slot: '0, out_device: '0,
                                out_block: '0, hit: 1'b0, fill_needed: 1'b0,
                                error: 1'b1, last: 1'b1};
                        end else begin
                            r_out <= '{kind: K_ACQ, out_slot: r_cq[0],
                                out_device: r_item.device_id,
                                out_block: r_item.block_number, hit: 1'b0,
                                fill_needed: r_item.opcode == OP_ACQ_RD,
                                error: 1'b0, last: 1'b1};
                            r_dev[r_cq[0]] <= r_item.device_id;
                            r_vdev[r_cq[0]] <= 1'b1;
                            r_blk[r_cq[0]] <= r_item.block_number;
                            r_st[r_cq[0]] <= ST_INVALID;
                            for (int k = 0; k < SLOTS - 1; k++) r_cq[k] <= r_cq[k + 1];
                            r_cc <= r_cc - 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out <= '{kind: K_DONE, out_slot: '0, out_device: '0,
                            out_block: '0, hit: 1'b0, fill_needed: 1'b0,
                            error: 1'b0, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
